@@ src/mfu_pkg.sv @@
// Shared types and constants for the modular fraction unit.
package mfu_pkg;

    localparam int MFU_MOD_RESET = 131;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_AMOD,
        S_NMOD,
        S_EDIV,
        S_EMUL,
        S_EUPD,
        S_EFIN,
        S_RMUL,
        S_RSTART,
        S_RMOD,
        S_DONE
    } mfu_state_t;

    typedef enum logic [1:0] {
        DIV_DEN,
        DIV_NUM,
        DIV_EUC,
        DIV_PROD
    } mfu_div_sel_t;

    typedef struct packed {
        logic         load_in;
        logic         div_start;
        mfu_div_sel_t div_sel;
        logic         init_euc;
        logic         take_nmod;
        logic         take_qr;
        logic         mul_step;
        logic         upd_t;
        logic         take_inv;
        logic         mul_res;
        logic         fin_err;
        logic         fin_zero;
        logic         fin_rem;
        logic         load_out;
    } mfu_cmd_t;

    typedef struct packed {
        logic m_zero;
        logic m_one;
        logic div_busy;
        logic div_done;
        logic rem_zero;
        logic r1_zero;
        logic r0_one;
    } mfu_sts_t;

endpackage

@@ src/mfu_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
module mfu_div #(
    parameter int WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               wide,
    input  logic [2*WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0]   divisor,
    output logic               busy,
    output logic               done,
    output logic [WIDTH-1:0]   quot,
    output logic [WIDTH-1:0]   rem
);

    localparam int CW = $clog2(2 * WIDTH + 1);

    logic [2*WIDTH-1:0] dvd_reg;
    logic [WIDTH-1:0]   rem_reg;
    logic [WIDTH-1:0]   dsr_reg;
    logic [CW-1:0]      cnt_reg;
    logic               busy_reg;

    logic [WIDTH:0]     partial;
    logic [WIDTH:0]     diff;
    logic               ge;
    logic [WIDTH-1:0]   rem_next;

    assign partial  = {rem_reg, dvd_reg[2*WIDTH-1]};
    assign diff     = partial - {1'b0, dsr_reg};
    assign ge       = ~diff[WIDTH];
    assign rem_next = ge ? diff[WIDTH-1:0] : partial[WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= wide ? CW'(2 * WIDTH) : CW'(WIDTH);
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            else
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= wide ? dividend : {dividend[WIDTH-1:0], {WIDTH{1'b0}}};
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            dvd_reg <= {dvd_reg[2*WIDTH-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign done = busy_reg && (cnt_reg == '0);
    assign quot = dvd_reg[WIDTH-1:0];
    assign rem  = rem_reg;

    // The partial remainder always stays below the divisor while a division runs.
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (cnt_reg != '0) |-> rem_reg < dsr_reg)
        else $error("divider remainder reached the divisor");

endmodule

@@ src/mfu_dp.sv @@
// Datapath: operand registers, Euclid state, multipliers and the result register.
module mfu_dp #(
    parameter int WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mfu_pkg::mfu_cmd_t cmd,
    output mfu_pkg::mfu_sts_t sts,
    input  logic             cfg_we,
    input  logic [WIDTH-1:0] cfg_data,
    input  logic [WIDTH-1:0] numerator,
    input  logic [WIDTH-1:0] denominator,
    output logic [WIDTH-1:0] residue,
    output logic             no_inverse
);

    import mfu_pkg::*;

    logic [WIDTH-1:0]          m_reg;
    logic [WIDTH-1:0]          num_reg;
    logic [WIDTH-1:0]          den_reg;
    logic [WIDTH-1:0]          r0_reg;
    logic [WIDTH-1:0]          r1_reg;
    logic signed [WIDTH+1:0]   t0_reg;
    logic signed [WIDTH+1:0]   t1_reg;
    logic [WIDTH-1:0]          q_reg;
    logic signed [2*WIDTH+2:0] step_prod_reg;
    logic [WIDTH-1:0]          nmod_reg;
    logic [WIDTH-1:0]          inv_reg;
    logic [2*WIDTH-1:0]        prod_reg;
    logic [WIDTH-1:0]          res_reg;
    logic                      err_reg;
    logic [WIDTH-1:0]          out_res_reg;
    logic                      out_err_reg;

    logic [WIDTH-1:0]          num_abs;
    logic [WIDTH-1:0]          nmod_next;
    logic signed [2*WIDTH+2:0] step_prod_next;
    logic signed [2*WIDTH+2:0] t_diff;
    logic signed [WIDTH+1:0]   t_wrap;
    logic [WIDTH-1:0]          inv_next;

    logic                      div_wide;
    logic [2*WIDTH-1:0]        div_dividend;
    logic [WIDTH-1:0]          div_divisor;
    logic                      div_busy;
    logic                      div_done;
    logic [WIDTH-1:0]          div_quot;
    logic [WIDTH-1:0]          div_rem;

    assign num_abs = num_reg[WIDTH-1] ? (~num_reg + {{(WIDTH-1){1'b0}}, 1'b1}) : num_reg;

    always_comb
    begin
        div_wide     = 1'b0;
        div_dividend = {{WIDTH{1'b0}}, den_reg};
        div_divisor  = m_reg;
        unique case (cmd.div_sel)
            DIV_DEN:
            begin
                div_dividend = {{WIDTH{1'b0}}, den_reg};
            end
            DIV_NUM:
            begin
                div_dividend = {{WIDTH{1'b0}}, num_abs};
            end
            DIV_EUC:
            begin
                div_dividend = {{WIDTH{1'b0}}, r0_reg};
                div_divisor  = r1_reg;
            end
            DIV_PROD:
            begin
                div_dividend = prod_reg;
                div_wide     = 1'b1;
            end
            default:
            begin
                div_dividend = {{WIDTH{1'b0}}, den_reg};
            end
        endcase
    end

    mfu_div #(
        .WIDTH(WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .wide     (div_wide),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // A negative numerator with a nonzero remainder folds to m minus that remainder.
    assign nmod_next = (num_reg[WIDTH-1] && (div_rem != '0)) ? (m_reg - div_rem) : div_rem;

    assign step_prod_next = $signed({1'b0, q_reg}) * t1_reg;
    assign t_diff         = (2*WIDTH+3)'(t0_reg) - step_prod_reg;
    assign t_wrap         = t0_reg + $signed({2'b00, m_reg});
    assign inv_next       = t0_reg[WIDTH+1] ? t_wrap[WIDTH-1:0] : t0_reg[WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg <= WIDTH'(MFU_MOD_RESET);
        end
        else if (cfg_we)
        begin
            m_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            num_reg <= numerator;
            den_reg <= denominator;
        end
        if (cmd.init_euc)
        begin
            r0_reg <= m_reg;
            r1_reg <= div_rem;
            t0_reg <= '0;
            t1_reg <= (WIDTH+2)'(1);
        end
        if (cmd.take_nmod)
        begin
            nmod_reg <= nmod_next;
        end
        if (cmd.take_qr)
        begin
            q_reg  <= div_quot;
            r0_reg <= r1_reg;
            r1_reg <= div_rem;
        end
        if (cmd.mul_step)
        begin
            step_prod_reg <= step_prod_next;
        end
        if (cmd.upd_t)
        begin
            t0_reg <= t1_reg;
            t1_reg <= t_diff[WIDTH+1:0];
        end
        if (cmd.take_inv)
        begin
            inv_reg <= inv_next;
        end
        if (cmd.mul_res)
        begin
            prod_reg <= nmod_reg * inv_reg;
        end
        if (cmd.fin_err)
        begin
            res_reg <= '0;
            err_reg <= 1'b1;
        end
        if (cmd.fin_zero)
        begin
            res_reg <= '0;
            err_reg <= 1'b0;
        end
        if (cmd.fin_rem)
        begin
            res_reg <= div_rem;
            err_reg <= 1'b0;
        end
        if (cmd.load_out)
        begin
            out_res_reg <= res_reg;
            out_err_reg <= err_reg;
        end
    end

    always_comb
    begin
        sts.m_zero   = (m_reg == '0);
        sts.m_one    = (m_reg == WIDTH'(1));
        sts.div_busy = div_busy;
        sts.div_done = div_done;
        sts.rem_zero = (div_rem == '0);
        sts.r1_zero  = (r1_reg == '0);
        sts.r0_one   = (r0_reg == WIDTH'(1));
    end

    assign residue    = out_res_reg;
    assign no_inverse = out_err_reg;

    // The final reduction must land in the canonical range.
    a_res_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin_rem |-> div_rem < m_reg)
        else $error("final residue not below the modulus");

    // An error result always carries a zero residue.
    a_err_zero_res: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out && err_reg |-> res_reg == '0)
        else $error("error result with nonzero residue");

endmodule

@@ src/mfu_ctrl.sv @@
// Controller: sequences the reduction, Euclid iterations and final multiply.
module mfu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  mfu_pkg::mfu_sts_t sts,
    output mfu_pkg::mfu_cmd_t cmd
);

    import mfu_pkg::*;

    mfu_state_t state_reg;
    mfu_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.m_zero)
                begin
                    cmd.fin_err = 1'b1;
                    state_next  = S_DONE;
                end
                else if (sts.m_one)
                begin
                    cmd.fin_zero = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_DEN;
                    state_next    = S_AMOD;
                end
            end
            S_AMOD:
            begin
                if (sts.div_done)
                begin
                    if (sts.rem_zero)
                    begin
                        cmd.fin_err = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        cmd.init_euc  = 1'b1;
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_NUM;
                        state_next    = S_NMOD;
                    end
                end
            end
            S_NMOD:
            begin
                cmd.div_sel = DIV_NUM;
                if (sts.div_done)
                begin
                    cmd.take_nmod = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_EUC;
                    state_next    = S_EDIV;
                end
            end
            S_EDIV:
            begin
                cmd.div_sel = DIV_EUC;
                if (sts.div_done)
                begin
                    cmd.take_qr = 1'b1;
                    state_next  = S_EMUL;
                end
            end
            S_EMUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = S_EUPD;
            end
            S_EUPD:
            begin
                cmd.upd_t = 1'b1;
                if (sts.r1_zero)
                begin
                    state_next = S_EFIN;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_EUC;
                    state_next    = S_EDIV;
                end
            end
            S_EFIN:
            begin
                if (sts.r0_one)
                begin
                    cmd.take_inv = 1'b1;
                    state_next   = S_RMUL;
                end
                else
                begin
                    cmd.fin_err = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_RMUL:
            begin
                cmd.mul_res = 1'b1;
                state_next  = S_RSTART;
            end
            S_RSTART:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_PROD;
                state_next    = S_RMOD;
            end
            S_RMOD:
            begin
                cmd.div_sel = DIV_PROD;
                if (sts.div_done)
                begin
                    cmd.fin_rem = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;

    // A new division is only launched on an idle or just-finishing divider.
    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy || sts.div_done)
        else $error("divider restarted while busy");

    // Divider completions arrive only in states that wait for one.
    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == S_AMOD) || (state_reg == S_NMOD) ||
                         (state_reg == S_EDIV) || (state_reg == S_RMOD))
        else $error("divider completion in an unexpected state");

endmodule

@@ src/modular_fraction_unit.sv @@
// Top level of the modular fraction unit: numerator times inverse of denominator mod m.
//
// Usage: input items arrive on the s_tvalid/s_tready/s_tdata stream, each holding a
// signed numerator and an unsigned denominator. The modulus m is written through the
// cfg_valid/cfg_ready channel (always ready) while the block is idle; it resets to 131.
// Each item gives exactly one result item on m_tvalid/m_tready: the residue in m_tdata
// and a no-inverse flag in m_tuser, set if m is zero or gcd(denominator, m) is not one.
// The serial divider produces one quotient bit per cycle and serves the reduction of the
// denominator, the folding of the numerator, every Euclid quotient and the final
// reduction of the product, so it sets how long an item takes. A modulus of zero or
// one skips the divider and finishes directly.
// One item is processed at a time; the next item is accepted once the current result
// has moved to the output register, even if the receiver has not taken it yet.
// When the receiver stalls, the result holds in the output register and a finished
// second item waits in the controller until the register frees up.
// Reset clears the controller, the divider and the output valid flag and loads the
// modulus with its reset value.
module modular_fraction_unit #(
    parameter int WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // From the lowest bit up: numerator, denominator, zero fill.
    input  logic [((2*WIDTH+7)/8)*8-1:0]         s_tdata,
    // Result stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // From the lowest bit up: residue, zero fill.
    output logic [((WIDTH+7)/8)*8-1:0]           m_tdata,
    // no_inverse flag.
    output logic                                 m_tuser,
    // Modulus write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [WIDTH-1:0]                     cfg_data
);

    import mfu_pkg::*;

    localparam int ODW = ((WIDTH + 7) / 8) * 8;

    mfu_cmd_t         cmd;
    mfu_sts_t         sts;
    logic [WIDTH-1:0] residue;
    logic             no_inverse;

    // The modulus register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    mfu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mfu_dp #(
        .WIDTH(WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_valid),
        .cfg_data    (cfg_data),
        .numerator   (s_tdata[WIDTH-1:0]),
        .denominator (s_tdata[2*WIDTH-1:WIDTH]),
        .residue     (residue),
        .no_inverse  (no_inverse)
    );

    assign m_tdata = ODW'(residue);
    assign m_tuser = no_inverse;

endmodule
